/* design/qstm_pkg.sv */
// ----------------------------------------------------------------------------
// qstm_pkg
// Shared constants, codes, Horner tables and sideband types of the quad-sphere
// tile membership pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qstm_pkg;

   // fixed point: Q2.30, operands carried as 34-bit signed
   localparam int FRAC_BITS = 30;
   localparam int TW        = FRAC_BITS + 1;
   localparam int QW        = 34;

   localparam logic [TW-1:0]        QONE_T = 31'h4000_0000;
   localparam logic [TW-1:0]        QSAT   = 31'h7FFF_FFFF;
   localparam logic signed [QW-1:0] QONE_S = 34'sd1073741824;

   // pi * 2^61 split into two 32-bit halves
   localparam logic [31:0] PI_HI = 32'h6487_ED51;
   localparam logic [31:0] PI_LO = 32'h10B4_611A;

   // series length
   localparam int HORNER_STEPS = 6;
   localparam int SIN_STEPS    = 5;

   // grid
   localparam int          N_W     = 13;
   localparam logic [12:0] MAX_RES = 13'd4096;

   // face codes
   localparam logic [2:0] FACE_NORTH = 3'd0;
   localparam logic [2:0] FACE_SOUTH = 3'd5;

   // pipeline depths in register stages
   localparam int SC_LAT   = 23;
   localparam int DIV_LAT  = 33;
   localparam int PIPE_LAT = SC_LAT + 3 * DIV_LAT + 3;

   // register map
   typedef enum logic [1:0] {
      REG_GRID_RES  = 2'd0,
      REG_TILE_FACE = 2'd1,
      REG_TILE_COL  = 2'd2,
      REG_TILE_ROW  = 2'd3
   } reg_index_type;

   // sideband carried beside the dividers
   typedef struct packed {
      logic [1:0]          quad;
      logic                pole;
      logic                pole_south;
      logic signed [31:0]  sa;
      logic signed [31:0]  ca;
      logic signed [31:0]  s1;
      logic signed [31:0]  c1;
   } d1_side_type;

   typedef struct packed {
      d1_side_type            s;
      logic signed [QW-1:0]   tp;
   } d2_side_type;

   typedef struct packed {
      logic [2:0] face;
      logic       pole;
      logic       polar;
   } d3_side_type;

   // sine series divisors, innermost first
   function automatic logic [7:0] sin_div(input int idx);
      logic [7:0] d;
      unique case (idx)
         0:       d = 8'd110;
         1:       d = 8'd72;
         2:       d = 8'd42;
         3:       d = 8'd20;
         4:       d = 8'd6;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   // floor(2^32 / sine divisor)
   function automatic logic [31:0] sin_recip(input int idx);
      logic [31:0] m;
      unique case (idx)
         0:       m = 32'd39045157;
         1:       m = 32'd59652323;
         2:       m = 32'd102261126;
         3:       m = 32'd214748364;
         4:       m = 32'd715827882;
         default: m = 32'd0;
      endcase
      return m;
   endfunction

   // cosine series divisors, innermost first
   function automatic logic [7:0] cos_div(input int idx);
      logic [7:0] d;
      unique case (idx)
         0:       d = 8'd132;
         1:       d = 8'd90;
         2:       d = 8'd56;
         3:       d = 8'd30;
         4:       d = 8'd12;
         5:       d = 8'd2;
         default: d = 8'd1;
      endcase
      return d;
   endfunction

   // floor(2^32 / cosine divisor)
   function automatic logic [31:0] cos_recip(input int idx);
      logic [31:0] m;
      unique case (idx)
         0:       m = 32'd32537631;
         1:       m = 32'd47721858;
         2:       m = 32'd76695844;
         3:       m = 32'd143165576;
         4:       m = 32'd357913941;
         5:       m = 32'd2147483648;
         default: m = 32'd0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

/* design/qstm_sincos.sv */
// ----------------------------------------------------------------------------
// qstm_sincos
// Pipelined sine and cosine of an angle in 2^-32 turn: quadrant reduction,
// radian scaling, Horner series with reciprocal division, quadrant rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module qstm_sincos (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [31:0]        ang,
   output logic               out_valid,
   output logic signed [31:0] sn,
   output logic signed [31:0] cs,
   output logic signed [31:0] rs,
   output logic signed [31:0] rc,
   output logic [1:0]         quad
);
   import qstm_pkg::*;

   // quadrant and rest magnitude
   logic [31:0] adj_w, r_w, mag_w;
   logic [1:0]  q_w;
   assign adj_w = ang + 32'h2000_0000;
   assign q_w   = adj_w[31:30];
   assign r_w   = ang - {q_w, 30'b0};
   assign mag_w = r_w[31] ? (~r_w + 32'd1) : r_w;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [1:0]  q1_ff, q2_ff, q3_ff, q4_ff;
   logic        n1_ff, n2_ff, n3_ff, n4_ff;
   logic [29:0] mag1_ff, x3_ff, x4_ff;
   logic [61:0] pa_ff, pb_ff, sum_w;
   logic [59:0] xx_ff;

   assign sum_w = pa_ff + {32'b0, pb_ff[61:32]};

   // front valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // radian scaling and square
   always_ff @(posedge clock) begin
      q1_ff   <= q_w;
      n1_ff   <= r_w[31];
      mag1_ff <= mag_w[29:0];
      q2_ff   <= q1_ff;
      n2_ff   <= n1_ff;
      pa_ff   <= {32'b0, mag1_ff} * {30'b0, PI_HI};
      pb_ff   <= {32'b0, mag1_ff} * {30'b0, PI_LO};
      q3_ff   <= q2_ff;
      n3_ff   <= n2_ff;
      x3_ff   <= sum_w[59:30];
      q4_ff   <= q3_ff;
      n4_ff   <= n3_ff;
      x4_ff   <= x3_ff;
      xx_ff   <= {30'b0, x3_ff} * {30'b0, x3_ff};
   end

   // step boundaries
   logic        st_v   [0:HORNER_STEPS];
   logic [1:0]  st_q   [0:HORNER_STEPS];
   logic        st_neg [0:HORNER_STEPS];
   logic [30:0] st_ts  [0:HORNER_STEPS];
   logic [30:0] st_tc  [0:HORNER_STEPS];
   logic [29:0] st_x   [0:HORNER_STEPS-1];
   logic [29:0] st_x2  [0:HORNER_STEPS-1];

   assign st_v[0]   = v4_ff;
   assign st_q[0]   = q4_ff;
   assign st_neg[0] = n4_ff;
   assign st_ts[0]  = QONE_T;
   assign st_tc[0]  = QONE_T;
   assign st_x[0]   = x4_ff;
   assign st_x2[0]  = xx_ff[59:30];

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      localparam logic [7:0]  CDIV = cos_div(i);
      localparam logic [31:0] CREC = cos_recip(i);

      logic        a_v_ff, b_v_ff, c_v_ff;
      logic [1:0]  a_q_ff, b_q_ff, c_q_ff;
      logic        a_n_ff, b_n_ff, c_n_ff;
      logic [60:0] a_pc_ff;
      logic [29:0] b_pc_ff;
      logic [61:0] b_rc_ff;
      logic [30:0] c_tc_ff;
      logic [29:0] cq0_w, cq_w;
      logic [37:0] cqd_w, crem_w;

      // cosine: quotient estimate and one correction
      assign cq0_w  = b_rc_ff[61:32];
      assign cqd_w  = {8'b0, cq0_w} * {30'b0, CDIV};
      assign crem_w = {8'b0, b_pc_ff} - cqd_w;
      assign cq_w   = cq0_w + {29'b0, (crem_w >= {30'b0, CDIV})};

      always_ff @(posedge clock) begin
         if (reset) begin
            a_v_ff <= 1'b0;
            b_v_ff <= 1'b0;
            c_v_ff <= 1'b0;
         end else begin
            a_v_ff <= st_v[i];
            b_v_ff <= a_v_ff;
            c_v_ff <= b_v_ff;
         end
      end

      always_ff @(posedge clock) begin
         a_q_ff  <= st_q[i];
         a_n_ff  <= st_neg[i];
         a_pc_ff <= {31'b0, st_x2[i]} * {30'b0, st_tc[i]};
         b_q_ff  <= a_q_ff;
         b_n_ff  <= a_n_ff;
         b_pc_ff <= a_pc_ff[59:30];
         b_rc_ff <= {32'b0, a_pc_ff[59:30]} * {30'b0, CREC};
         c_q_ff  <= b_q_ff;
         c_n_ff  <= b_n_ff;
         c_tc_ff <= QONE_T - {1'b0, cq_w};
      end

      assign st_v[i+1]   = c_v_ff;
      assign st_q[i+1]   = c_q_ff;
      assign st_neg[i+1] = c_n_ff;
      assign st_tc[i+1]  = c_tc_ff;

      if (i < SIN_STEPS) begin : g_sin_horner
         localparam logic [7:0]  SDIV = sin_div(i);
         localparam logic [31:0] SREC = sin_recip(i);

         logic [60:0] a_ps_ff;
         logic [29:0] b_ps_ff;
         logic [61:0] b_rs_ff;
         logic [30:0] c_ts_ff;
         logic [29:0] sq0_w, sq_w;
         logic [37:0] sqd_w, srem_w;

         // sine: quotient estimate and one correction
         assign sq0_w  = b_rs_ff[61:32];
         assign sqd_w  = {8'b0, sq0_w} * {30'b0, SDIV};
         assign srem_w = {8'b0, b_ps_ff} - sqd_w;
         assign sq_w   = sq0_w + {29'b0, (srem_w >= {30'b0, SDIV})};

         always_ff @(posedge clock) begin
            a_ps_ff <= {31'b0, st_x2[i]} * {30'b0, st_ts[i]};
            b_ps_ff <= a_ps_ff[59:30];
            b_rs_ff <= {32'b0, a_ps_ff[59:30]} * {30'b0, SREC};
            c_ts_ff <= QONE_T - {1'b0, sq_w};
         end

         assign st_ts[i+1] = c_ts_ff;
      end else begin : g_sin_final
         logic [60:0] a_ps_ff;
         logic [29:0] b_ps_ff;
         logic [30:0] c_ts_ff;

         // final multiply by x, held to line up with the cosine
         always_ff @(posedge clock) begin
            a_ps_ff <= {31'b0, st_x[i]} * {30'b0, st_ts[i]};
            b_ps_ff <= a_ps_ff[59:30];
            c_ts_ff <= {1'b0, b_ps_ff};
         end

         assign st_ts[i+1] = c_ts_ff;
      end

      if (i < HORNER_STEPS - 1) begin : g_carry
         logic [29:0] a_x_ff, b_x_ff, c_x_ff;
         logic [29:0] a_x2_ff, b_x2_ff, c_x2_ff;

         always_ff @(posedge clock) begin
            a_x_ff  <= st_x[i];
            b_x_ff  <= a_x_ff;
            c_x_ff  <= b_x_ff;
            a_x2_ff <= st_x2[i];
            b_x2_ff <= a_x2_ff;
            c_x2_ff <= b_x2_ff;
         end

         assign st_x[i+1]  = c_x_ff;
         assign st_x2[i+1] = c_x2_ff;
      end
   end

   // sign of the rest and quadrant rotation
   logic signed [31:0] s0_w, c0_w, sg_w, sn_in, cs_in;
   assign s0_w = signed'({1'b0, st_ts[HORNER_STEPS]});
   assign c0_w = signed'({1'b0, st_tc[HORNER_STEPS]});
   assign sg_w = st_neg[HORNER_STEPS] ? -s0_w : s0_w;

   always_comb begin
      unique case (st_q[HORNER_STEPS])
         2'd0: begin
            sn_in = sg_w;
            cs_in = c0_w;
         end
         2'd1: begin
            sn_in = c0_w;
            cs_in = -sg_w;
         end
         2'd2: begin
            sn_in = -sg_w;
            cs_in = -c0_w;
         end
         default: begin
            sn_in = -c0_w;
            cs_in = sg_w;
         end
      endcase
   end

   logic               out_v_ff;
   logic signed [31:0] sn_ff, cs_ff, rs_ff, rc_ff;
   logic [1:0]         quad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= st_v[HORNER_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      sn_ff   <= sn_in;
      cs_ff   <= cs_in;
      rs_ff   <= sg_w;
      rc_ff   <= c0_w;
      quad_ff <= st_q[HORNER_STEPS];
   end

   assign out_valid = out_v_ff;
   assign sn        = sn_ff;
   assign cs        = cs_ff;
   assign rs        = rs_ff;
   assign rc        = rc_ff;
   assign quad      = quad_ff;

endmodule

`default_nettype wire

/* design/qstm_div.sv */
// ----------------------------------------------------------------------------
// qstm_div
// Pipelined signed Q2.30 divider, one restoring quotient bit per stage,
// saturating to a magnitude of two minus one lsb; carries a sideband word.
// ----------------------------------------------------------------------------
`default_nettype none

module qstm_div #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [qstm_pkg::QW-1:0] num,
   input  logic signed [qstm_pkg::QW-1:0] den,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic signed [qstm_pkg::QW-1:0] quo,
   output logic [SIDE_W-1:0]             out_side
);
   import qstm_pkg::*;

   localparam int QBITS = TW;

   // magnitudes, sign, saturation and zero detection
   logic [QW-1:0] num_u, den_u, un_w, ud_w;
   assign num_u = num;
   assign den_u = den;
   assign un_w  = num[QW-1] ? (~num_u + 1'b1) : num_u;
   assign ud_w  = den[QW-1] ? (~den_u + 1'b1) : den_u;

   logic              bs_v    [0:QBITS];
   logic [QW:0]       bs_rem  [0:QBITS];
   logic [QBITS-1:0]  bs_q    [0:QBITS];
   logic [QW-1:0]     bs_ud   [0:QBITS];
   logic              bs_neg  [0:QBITS];
   logic              bs_zero [0:QBITS];
   logic              bs_sat  [0:QBITS];
   logic [SIDE_W-1:0] bs_side [0:QBITS];

   logic              e_v_ff, e_neg_ff, e_zero_ff, e_sat_ff;
   logic [QW:0]       e_rem_ff;
   logic [QW-1:0]     e_ud_ff;
   logic [SIDE_W-1:0] e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else begin
         e_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      e_neg_ff  <= num[QW-1] ^ den[QW-1];
      e_zero_ff <= (un_w == '0);
      e_sat_ff  <= ({1'b0, un_w} >= {ud_w, 1'b0});
      e_rem_ff  <= {1'b0, un_w};
      e_ud_ff   <= ud_w;
      e_side_ff <= in_side;
   end

   assign bs_v[0]    = e_v_ff;
   assign bs_rem[0]  = e_rem_ff;
   assign bs_q[0]    = '0;
   assign bs_ud[0]   = e_ud_ff;
   assign bs_neg[0]  = e_neg_ff;
   assign bs_zero[0] = e_zero_ff;
   assign bs_sat[0]  = e_sat_ff;
   assign bs_side[0] = e_side_ff;

   for (genvar j = 0; j < QBITS; j++) begin : g_bit
      logic [QW:0]       remw_w, remn_w;
      logic              ge_w;
      logic              v_ff, neg_ff, zero_ff, sat_ff;
      logic [QW:0]       rem_ff;
      logic [QBITS-1:0]  q_ff;
      logic [QW-1:0]     ud_ff;
      logic [SIDE_W-1:0] side_ff;

      // shift in the next bit, compare and subtract
      assign remw_w = (j == 0) ? bs_rem[j] : {bs_rem[j][QW-1:0], 1'b0};
      assign ge_w   = (remw_w >= {1'b0, bs_ud[j]});
      assign remn_w = ge_w ? (remw_w - {1'b0, bs_ud[j]}) : remw_w;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else begin
            v_ff <= bs_v[j];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff  <= remn_w;
         q_ff    <= {bs_q[j][QBITS-2:0], ge_w};
         ud_ff   <= bs_ud[j];
         neg_ff  <= bs_neg[j];
         zero_ff <= bs_zero[j];
         sat_ff  <= bs_sat[j];
         side_ff <= bs_side[j];
      end

      assign bs_v[j+1]    = v_ff;
      assign bs_rem[j+1]  = rem_ff;
      assign bs_q[j+1]    = q_ff;
      assign bs_ud[j+1]   = ud_ff;
      assign bs_neg[j+1]  = neg_ff;
      assign bs_zero[j+1] = zero_ff;
      assign bs_sat[j+1]  = sat_ff;
      assign bs_side[j+1] = side_ff;
   end

   // saturation and sign
   logic signed [QW-1:0] mag_w, quo_in;
   always_comb begin
      priority if (bs_zero[QBITS]) begin
         mag_w = '0;
      end else if (bs_sat[QBITS]) begin
         mag_w = QW'(QSAT);
      end else begin
         mag_w = QW'(bs_q[QBITS]);
      end
   end
   assign quo_in = bs_neg[QBITS] ? -mag_w : mag_w;

   logic                 o_v_ff;
   logic signed [QW-1:0] quo_ff;
   logic [SIDE_W-1:0]    o_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else begin
         o_v_ff <= bs_v[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      o_side_ff <= bs_side[QBITS];
   end

   assign out_valid = o_v_ff;
   assign quo       = quo_ff;
   assign out_side  = o_side_ff;

endmodule

`default_nettype wire

/* design/quad_sphere_tile_membership.sv */
// Throughput: one item per cycle; busy stays low, results are never held off.
// Depth is set by the series sine/cosine pipeline and three chained
// bit-per-stage dividers (tangent, equatorial height, face coordinates).
// Synchronous active-high reset clears all valid bits and the registers to
// grid_resolution 3, tile face, column and row 0.
// ----------------------------------------------------------------------------
// quad_sphere_tile_membership
// Projects sky positions onto the six-face quad-sphere, finds the grid cell
// and flags whether it is the configured tile.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_sphere_tile_membership (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_right_ascension,
   input  logic [31:0] req_declination,
   // item result
   output logic        rsp_strobe,
   output logic        rsp_inside_res,
   output logic [2:0]  rsp_face,
   output logic [11:0] rsp_cell_col,
   output logic [11:0] rsp_cell_row,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import qstm_pkg::*;

   // configuration registers
   logic [12:0]   grid_ff;
   logic [2:0]    tile_face_ff;
   logic [11:0]   tile_col_ff, tile_row_ff;
   reg_index_type csr_idx;
   logic          csr_wr;

   assign csr_idx = reg_index_type'(paddr[3:2]);
   assign csr_wr  = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff      <= 13'd3;
         tile_face_ff <= FACE_NORTH;
         tile_col_ff  <= '0;
         tile_row_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GRID_RES:  grid_ff      <= pwdata[12:0];
            REG_TILE_FACE: tile_face_ff <= pwdata[2:0];
            REG_TILE_COL:  tile_col_ff  <= pwdata[11:0];
            REG_TILE_ROW:  tile_row_ff  <= pwdata[11:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_GRID_RES:  prdata = {19'b0, grid_ff};
         REG_TILE_FACE: prdata = {29'b0, tile_face_ff};
         REG_TILE_COL:  prdata = {20'b0, tile_col_ff};
         REG_TILE_ROW:  prdata = {20'b0, tile_row_ff};
      endcase
   end

   assign busy = 1'b0;

   // sine and cosine of both angles
   logic               ra_v, dec_v;
   logic signed [31:0] sa, ca, s1, c1, sd, cd;
   logic [1:0]         quad;

   qstm_sincos u_sc_ra (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .ang       (req_right_ascension),
      .out_valid (ra_v),
      .sn        (sa),
      .cs        (ca),
      .rs        (s1),
      .rc        (c1),
      .quad      (quad)
   );

   qstm_sincos u_sc_dec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .ang       (req_declination),
      .out_valid (dec_v),
      .sn        (sd),
      .cs        (cd),
      .rs        (),
      .rc        (),
      .quad      ()
   );

   // tangent of declination
   d1_side_type          d1_in, d1_out;
   logic                 d1_v;
   logic signed [QW-1:0] tp;

   assign d1_in.quad       = quad;
   assign d1_in.pole       = (cd == 32'sd0);
   assign d1_in.pole_south = sd[31];
   assign d1_in.sa         = sa;
   assign d1_in.ca         = ca;
   assign d1_in.s1         = s1;
   assign d1_in.c1         = c1;

   qstm_div #(.SIDE_W($bits(d1_side_type))) u_div_tp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ra_v & dec_v),
      .num       (QW'(sd)),
      .den       (QW'(cd)),
      .in_side   (d1_in),
      .out_valid (d1_v),
      .quo       (tp),
      .out_side  (d1_out)
   );

   // height on the equatorial face
   d2_side_type          d2_in, d2_out;
   logic                 d2_v;
   logic signed [QW-1:0] ye;

   assign d2_in.s  = d1_out;
   assign d2_in.tp = tp;

   qstm_div #(.SIDE_W($bits(d2_side_type))) u_div_ye (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d1_v),
      .num       (tp),
      .den       (QW'(d1_out.c1)),
      .in_side   (d2_in),
      .out_valid (d2_v),
      .quo       (ye),
      .out_side  (d2_out)
   );

   // face choice and face-coordinate operands
   logic                 north_w, south_w;
   logic [2:0]           face_w;
   logic signed [QW-1:0] n3_w, d3_w;
   d3_side_type          d3_in, d3_out;

   assign north_w = (ye > QONE_S);
   assign south_w = (ye < -QONE_S);

   always_comb begin
      priority if (d2_out.s.pole) begin
         face_w = d2_out.s.pole_south ? FACE_SOUTH : FACE_NORTH;
      end else if (north_w) begin
         face_w = FACE_NORTH;
      end else if (south_w) begin
         face_w = FACE_SOUTH;
      end else begin
         face_w = {1'b0, d2_out.s.quad} + 3'd1;
      end
   end

   always_comb begin
      priority if (north_w) begin
         n3_w = -QW'(d2_out.s.sa);
         d3_w = d2_out.tp;
      end else if (south_w) begin
         n3_w = QW'(d2_out.s.sa);
         d3_w = d2_out.tp;
      end else begin
         n3_w = QW'(d2_out.s.s1);
         d3_w = QW'(d2_out.s.c1);
      end
   end

   assign d3_in.face  = face_w;
   assign d3_in.pole  = d2_out.s.pole;
   assign d3_in.polar = north_w | south_w;

   logic                 d3_v;
   logic signed [QW-1:0] px_q, py_q, ye_d;

   qstm_div #(.SIDE_W($bits(d3_side_type))) u_div_px (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d2_v),
      .num       (n3_w),
      .den       (d3_w),
      .in_side   (d3_in),
      .out_valid (d3_v),
      .quo       (px_q),
      .out_side  (d3_out)
   );

   qstm_div #(.SIDE_W(QW)) u_div_py (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d2_v),
      .num       (QW'(d2_out.s.ca)),
      .den       (d2_out.tp),
      .in_side   (ye),
      .out_valid (),
      .quo       (py_q),
      .out_side  (ye_d)
   );

   // coordinates shifted into [0, 2]
   logic signed [QW-1:0] px_w, py_w;
   assign px_w = d3_out.pole ? '0 : px_q;
   assign py_w = d3_out.pole ? '0 : (d3_out.polar ? py_q : ye_d);

   logic                 c1_v_ff, c2_v_ff, out_v_ff;
   logic signed [QW-1:0] wx_ff, wy_ff;
   logic [2:0]           c1_face_ff, c2_face_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff  <= 1'b0;
         c2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         c1_v_ff  <= d3_v;
         c2_v_ff  <= c1_v_ff;
         out_v_ff <= c2_v_ff;
      end
   end

   // effective resolution
   logic [N_W-1:0] n_w;
   always_comb begin
      priority if (grid_ff == '0) begin
         n_w = 13'd1;
      end else if (grid_ff > MAX_RES) begin
         n_w = MAX_RES;
      end else begin
         n_w = grid_ff;
      end
   end

   // cell scaling
   logic        xpos_ff, ypos_ff;
   logic [44:0] prod_x_ff, prod_y_ff;

   always_ff @(posedge clock) begin
      wx_ff      <= px_w + QONE_S;
      wy_ff      <= py_w + QONE_S;
      c1_face_ff <= d3_out.face;
      xpos_ff    <= (wx_ff > 34'sd0);
      ypos_ff    <= (wy_ff > 34'sd0);
      prod_x_ff  <= {32'b0, n_w} * {13'b0, wx_ff[31:0]};
      prod_y_ff  <= {32'b0, n_w} * {13'b0, wy_ff[31:0]};
      c2_face_ff <= c1_face_ff;
   end

   // clamp and tile match
   logic [13:0]    cx_w, cy_w;
   logic [N_W-1:0] col_w, row_w;

   assign cx_w  = prod_x_ff[44:31];
   assign cy_w  = prod_y_ff[44:31];
   assign col_w = !xpos_ff ? '0 :
                  ((cx_w >= {1'b0, n_w}) ? (n_w - 13'd1) : cx_w[12:0]);
   assign row_w = !ypos_ff ? '0 :
                  ((cy_w >= {1'b0, n_w}) ? (n_w - 13'd1) : cy_w[12:0]);

   logic        inside_ff;
   logic [2:0]  face_ff;
   logic [11:0] col_ff, row_ff;

   always_ff @(posedge clock) begin
      inside_ff <= (c2_face_ff == tile_face_ff) && (col_w[11:0] == tile_col_ff) &&
                   (row_w[11:0] == tile_row_ff);
      face_ff   <= c2_face_ff;
      col_ff    <= col_w[11:0];
      row_ff    <= row_w[11:0];
   end

   assign rsp_strobe     = out_v_ff;
   assign rsp_inside_res = inside_ff;
   assign rsp_face       = face_ff;
   assign rsp_cell_col   = col_ff;
   assign rsp_cell_row   = row_ff;

endmodule

`default_nettype wire

/* design/qstm_checker.sv */
// ----------------------------------------------------------------------------
// qstm_checker
// Port-level checks of the tile membership block: fixed latency, no stall,
// legal face codes and an always-ready register port.
// ----------------------------------------------------------------------------
`default_nettype none

module qstm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_right_ascension,
   input logic [31:0] req_declination,
   input logic        rsp_strobe,
   input logic        rsp_inside_res,
   input logic [2:0]  rsp_face,
   input logic [11:0] rsp_cell_col,
   input logic [11:0] rsp_cell_row,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [3:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);
   import qstm_pkg::*;

   // the block never pushes back on items
   a_no_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every result follows an accepted item by the pipeline depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, PIPE_LAT))
      else $error("result without item at pipeline depth");

   // face is one of the six cube faces
   a_face : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_face <= FACE_SOUTH))
      else $error("face out of range");

   // register access is never stalled: pready is high whenever psel and penable are
   a_ready : assert property (@(posedge clock) disable iff (reset)
      (psel && penable) |-> pready)
      else $error("register access stalled");

endmodule

bind quad_sphere_tile_membership qstm_checker u_qstm_checker (.*);

`default_nettype wire
